// ===== hdl/fic_pkg.sv =====
// Package for the firmware image checksum block.
// Holds mode, error and register codes, the CRC nibble table and the word CRC function.
// No dependencies.
package fic_pkg;

	// Checksum mode codes; code 3 is unused and behaves as none.
	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_SUM  = 2'd1;
	localparam logic [1:0] MODE_CRC  = 2'd2;

	// Error codes reported with the result.
	localparam logic [1:0] ERR_OK      = 2'd0;
	localparam logic [1:0] ERR_CRC_LEN = 2'd1;
	localparam logic [1:0] ERR_OVERRUN = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_MODE   = 1'b0;
	localparam logic CFG_WINDOW = 1'b1;

	localparam logic [31:0] CRC_POLY    = 32'h04C1_1DB7;
	localparam logic [31:0] ERASED_WORD = 32'hFFFF_FFFF;
	localparam logic [23:0] WORDS_MAX   = 24'hFF_FFFF;
	localparam logic [23:0] WINDOW_RST  = 24'd65536;

	// Configuration as seen by the accumulator.
	typedef struct packed {
		logic [1:0]  mode;
		logic [23:0] window;
		logic        restart;
		logic [1:0]  new_mode;
	} fic_cfg_t;

	// One result transaction.
	typedef struct packed {
		logic [31:0] checksum_word;
		logic        checksum_present;
		logic [1:0]  error_code;
	} fic_result_t;

	// Table entry: the top nibble n shifted four bits through the polynomial.
	function automatic logic [31:0] crc_nib_entry(input int n);
		logic [31:0] c;
		c = {n[3:0], 28'd0};
		for (int k = 0; k < 4; k++) begin
			c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
		end
		return c;
	endfunction

	localparam logic [31:0] CRC_NIB [16] = '{
		crc_nib_entry(0),  crc_nib_entry(1),  crc_nib_entry(2),  crc_nib_entry(3),
		crc_nib_entry(4),  crc_nib_entry(5),  crc_nib_entry(6),  crc_nib_entry(7),
		crc_nib_entry(8),  crc_nib_entry(9),  crc_nib_entry(10), crc_nib_entry(11),
		crc_nib_entry(12), crc_nib_entry(13), crc_nib_entry(14), crc_nib_entry(15)
	};

	// MSB-first CRC over one 32-bit word, four bits per table step.
	function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] word);
		logic [31:0] c;
		c = crc ^ word;
		for (int k = 0; k < 8; k++) begin
			c = {c[27:0], 4'd0} ^ CRC_NIB[c[31:28]];
		end
		return c;
	endfunction

endpackage

// ===== hdl/fic_if.sv =====
// Stream interfaces of the firmware image checksum block.
// Carry valid, ready and payload for image bytes and checksum results; no dependencies.
interface fic_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, data_byte, last_byte, input ready);
	modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface fic_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] checksum_word;
	logic        checksum_present;
	logic [1:0]  error_code;

	modport source (output valid, checksum_word, checksum_present, error_code, input ready);
	modport sink (input valid, checksum_word, checksum_present, error_code, output ready);
endinterface

// ===== hdl/firmware_image_checksum.sv =====
// Firmware image checksum: an accepted final byte passes the input register, then the
// result register, before it is offered as the result transaction.
// Throughput is one byte per cycle; the input stalls only while a finished result
// waits and a further final byte is held in the input register.
// Reset clears configuration to crc32 mode with a 65536-byte window and restarts the image.
// Depends on fic_pkg, fic_if and fic_accum.
module firmware_image_checksum import fic_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	fic_byte_if.sink            image,
	fic_result_if.source        checksum,
	input  logic                write_en,
	input  logic                write_index,
	input  logic [23:0]         write_data
);

	logic        mode_restart;
	logic [1:0]  mode_q;
	logic [23:0] window_q;
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        out_valid_q;
	fic_result_t out_q;
	fic_result_t result;
	fic_cfg_t    cfg;
	logic        out_free;
	logic        go_s1;
	logic        proc;

	// Configuration registers.
	assign mode_restart = write_en && (write_index == CFG_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_CRC;
			window_q <= WINDOW_RST;
		end else if (write_en) begin
			case (write_index)
				CFG_MODE:   mode_q   <= write_data[1:0];
				CFG_WINDOW: window_q <= write_data;
				default:    mode_q   <= mode_q;
			endcase
		end
	end

	assign cfg = '{mode: mode_q, window: window_q, restart: mode_restart,
		new_mode: write_data[1:0]};

	// The input stage moves on unless a final byte meets an occupied result register that is not being taken.
	assign out_free    = !out_valid_q || checksum.ready;
	assign go_s1       = !last_s1 || out_free;
	assign proc        = valid_s1 && go_s1;
	assign image.ready = !valid_s1 || go_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (image.ready) begin
			valid_s1 <= image.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (image.ready && image.valid) begin
			data_s1 <= image.data_byte;
			last_s1 <= image.last_byte;
		end
	end

	fic_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.proc      (proc),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.cfg       (cfg),
		.result    (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (checksum.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && last_s1) begin
			out_q <= result;
		end
	end

	assign checksum.valid            = out_valid_q;
	assign checksum.checksum_word    = out_q.checksum_word;
	assign checksum.checksum_present = out_q.checksum_present;
	assign checksum.error_code       = out_q.error_code;

endmodule

// ===== hdl/fic_accum.sv =====
// Word gathering, CRC or sum accumulation and final checksum computation.
// Depends on fic_pkg.
module fic_accum import fic_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        proc,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  fic_cfg_t    cfg,
	output fic_result_t result
);

	logic [23:0] partial_q;
	logic [1:0]  biw_q;
	logic [31:0] run_q;
	logic [23:0] ws_q;
	logic        ovr_q;

	logic [31:0] word;
	logic        full;
	logic        take;
	logic [31:0] crc_next;
	logic [31:0] sum_next;
	logic [23:0] ws_inc;
	logic        ovr_now;
	logic [31:0] run_f;
	logic [23:0] ws_f;
	logic        ovr_f;
	logic [23:0] limit;
	logic [25:0] size;
	logic [24:0] diff3;
	logic [31:0] pad;
	logic [31:0] run_init;
	logic [31:0] run_restart;

	// Assemble the little-endian word with the incoming byte.
	assign word = {8'd0, partial_q} | ({24'd0, data_byte} << {biw_q, 3'b000});
	assign full = (biw_q == 2'd3);
	assign take = full || last_byte;

	// Candidate updates for both modes.
	assign crc_next = crc_word(run_q, word);
	assign sum_next = run_q + word;
	assign ws_inc   = (ws_q != WORDS_MAX) ? ws_q + 24'd1 : ws_q;
	assign ovr_now  = ({1'b0, ws_inc, 2'b00} + 27'd4) > {3'd0, cfg.window};

	// State after the word of this byte, if any, has been taken.
	always_comb begin
		run_f = run_q;
		ws_f  = ws_q;
		ovr_f = ovr_q;
		if (take) begin
			case (cfg.mode)
				MODE_CRC: run_f = crc_next;
				MODE_SUM: begin
					run_f = sum_next;
					ws_f  = ws_inc;
					ovr_f = ovr_q | ovr_now;
				end
				default: run_f = run_q;
			endcase
		end
	end

	// Padding with erased words subtracts one per word, so the result is pad - sum.
	assign limit = (cfg.window >= 24'd4) ? cfg.window - 24'd4 : 24'd0;
	assign size  = {ws_f, 2'b00};
	assign diff3 = {1'b0, limit} - size[24:0] + 25'd3;
	assign pad   = ({2'd0, size} < {4'd0, limit}) ? {9'd0, diff3[24:2]} : 32'd0;

	// Result of the final byte.
	always_comb begin
		result = '0;
		case (cfg.mode)
			MODE_CRC: begin
				result.checksum_word    = run_f;
				result.checksum_present = 1'b1;
				result.error_code       = full ? ERR_OK : ERR_CRC_LEN;
			end
			MODE_SUM: begin
				result.checksum_word    = pad - run_f;
				result.checksum_present = 1'b1;
				result.error_code       = ovr_f ? ERR_OVERRUN : ERR_OK;
			end
			default: result = '0;
		endcase
	end

	assign run_init    = (cfg.mode == MODE_CRC) ? ERASED_WORD : 32'd0;
	assign run_restart = (cfg.new_mode == MODE_CRC) ? ERASED_WORD : 32'd0;

	// Image state; a mode write or the final byte restarts the image.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			biw_q     <= '0;
			run_q     <= ERASED_WORD;
			ws_q      <= '0;
			ovr_q     <= 1'b0;
		end else if (cfg.restart) begin
			partial_q <= '0;
			biw_q     <= '0;
			run_q     <= run_restart;
			ws_q      <= '0;
			ovr_q     <= 1'b0;
		end else if (proc) begin
			if (last_byte) begin
				partial_q <= '0;
				biw_q     <= '0;
				run_q     <= run_init;
				ws_q      <= '0;
				ovr_q     <= 1'b0;
			end else begin
				partial_q <= full ? 24'd0 : word[23:0];
				biw_q     <= biw_q + 2'd1;
				run_q     <= run_f;
				ws_q      <= ws_f;
				ovr_q     <= ovr_f;
			end
		end
	end

endmodule

// ===== hdl/fic_checker.sv =====
// Port checker for the firmware image checksum block, bound to the top level.
// Depends on fic_pkg.
module fic_port_checker import fic_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] checksum_word,
	input logic        checksum_present,
	input logic [1:0]  error_code
);

	// A pending result stays offered until it is taken.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before acceptance");

	// A pending result keeps its checksum word and error code.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(checksum_word) && $stable(error_code))
		else $error("result payload changed while stalled");

	// Without a checksum the word is zero and no error is reported.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !checksum_present |-> checksum_word == 32'd0 && error_code == ERR_OK)
		else $error("none-mode result carries data");

	// Only the defined error codes appear.
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_code == ERR_OK || error_code == ERR_CRC_LEN
			|| error_code == ERR_OVERRUN)
		else $error("undefined error code");

endmodule

bind firmware_image_checksum fic_port_checker u_fic_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (checksum.valid),
	.out_ready        (checksum.ready),
	.checksum_word    (checksum.checksum_word),
	.checksum_present (checksum.checksum_present),
	.error_code       (checksum.error_code)
);

// ===== dv/fic_checker.sv =====
// Checker for the firmware image checksum block: watches the byte, result and register ports.
// Predicts each checksum from its own copy of the image state and compares field by field.
// Depends on fic_pkg and the stream interfaces in fic_if.
module fic_checker
	import fic_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	fic_byte_if         image,
	fic_result_if       checksum,
	input  logic        write_en,
	input  logic        write_index,
	input  logic [23:0] write_data,
	output int unsigned failures,
	output int unsigned pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Predicted configuration and image state.
	logic [1:0]  mode;
	logic [23:0] window;
	logic [23:0] partial;
	logic [1:0]  byte_count;
	logic [31:0] running;
	logic [23:0] word_count;
	logic        overrun;

	fic_result_t checksum_q[$];
	int unsigned fail_count = 0;
	int unsigned waiting = 0;

	assign failures = fail_count;
	assign pending  = waiting;

	// Bitwise MSB-first CRC over one word, no final inversion.
	function automatic logic [31:0] crc32_word(input logic [31:0] crc, input logic [31:0] word);
		logic [31:0] c;
		c = crc ^ word;
		repeat (32) c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
		return c;
	endfunction

	// A new image starts from the seed of the current mode.
	task automatic restart_image();
		partial    = '0;
		byte_count = '0;
		running    = (mode == MODE_CRC) ? ERASED_WORD : 32'd0;
		word_count = '0;
		overrun    = 1'b0;
	endtask

	// Fold one complete word into the running CRC or sum.
	task automatic fold_word(input logic [31:0] word);
		longint unsigned span;
		if (mode == MODE_CRC) begin
			running = crc32_word(running, word);
		end else if (mode == MODE_SUM) begin
			running = running + word;
			if (word_count != WORDS_MAX) word_count++;
			span = word_count;
			span = span * 4 + 4;
			if (span > window) overrun = 1'b1;
		end
	endtask

	// One accepted byte; the final byte of an image queues the expected checksum.
	task automatic take_byte(input logic [7:0] b, input logic last);
		logic [31:0]     word;
		logic            full;
		fic_result_t     r;
		longint unsigned limit;
		longint unsigned size;
		longint unsigned pad;
		longint unsigned wrap;
		logic [31:0]     total;
		word = {8'h00, partial} | ({24'h0, b} << (8 * byte_count));
		full = (byte_count == 2'd3);
		if (full) begin
			fold_word(word);
			partial    = '0;
			byte_count = '0;
		end else begin
			partial    = word[23:0];
			byte_count = byte_count + 2'd1;
		end
		if (last) begin
			// A short last word is zero-filled and still folded in.
			if (!full) fold_word(word);
			r = '0;
			r.error_code = ERR_OK;
			if (mode == MODE_CRC) begin
				r.checksum_word    = running;
				r.checksum_present = 1'b1;
				r.error_code       = full ? ERR_OK : ERR_CRC_LEN;
			end else if (mode == MODE_SUM) begin
				// Erased words pad the image up to the window less the checksum word.
				limit = (window >= 24'd4) ? window - 24'd4 : 0;
				size  = word_count;
				size  = size * 4;
				total = running;
				if (size < limit) begin
					pad   = (limit - size + 3) / 4;
					wrap  = pad * ERASED_WORD;
					total = total + wrap[31:0];
				end
				r.checksum_word    = 32'd0 - total;
				r.checksum_present = 1'b1;
				r.error_code       = overrun ? ERR_OVERRUN : ERR_OK;
			end
			checksum_q = {checksum_q, r};
			restart_image();
		end
	endtask

	task automatic report(input string msg);
		$display("%0d ns: %s", $time, msg);
		fail_count++;
	endtask

	// Compare one result transaction with the oldest expected checksum.
	task automatic check_result();
		fic_result_t want;
		if (checksum_q.size() == 0) begin
			report($sformatf("unexpected result: word %h present %0d error %0d",
				checksum.checksum_word, checksum.checksum_present, checksum.error_code));
			return;
		end
		want = checksum_q.pop_front();
		if (checksum.checksum_word !== want.checksum_word)
			report($sformatf("checksum_word: expected %h, got %h",
				want.checksum_word, checksum.checksum_word));
		if (checksum.checksum_present !== want.checksum_present)
			report($sformatf("checksum_present: expected %0d, got %0d",
				want.checksum_present, checksum.checksum_present));
		if (checksum.error_code !== want.error_code)
			report($sformatf("error_code: expected %0d, got %0d",
				want.error_code, checksum.error_code));
	endtask

	// Results are taken before bytes so a fresh expectation never matches a result of this edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode   = MODE_CRC;
			window = WINDOW_RST;
			restart_image();
			checksum_q.delete();
		end else begin
			if (write_en) begin
				if (write_index == CFG_MODE) begin
					mode = write_data[1:0];
					restart_image();
				end else begin
					window = write_data;
				end
			end
			if (checksum.valid && checksum.ready) check_result();
			if (image.valid && image.ready) take_byte(image.data_byte, image.last_byte);
		end
		waiting = checksum_q.size();
	end

endmodule

// ===== dv/tb.sv =====
// Top of the firmware image checksum testbench: clock, reset, byte and register stimulus.
// Instantiates the block and fic_checker side by side and reports the verdict.
// Depends on fic_pkg, fic_if, firmware_image_checksum and fic_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fic_pkg::*;

	localparam logic [1:0] MODE_SPARE   = 2'd3;
	localparam int         DRAIN_CYCLES = 4;
	localparam int         FILL_ZERO    = 0;
	localparam int         FILL_ONES    = 1;
	localparam int         FILL_RANDOM  = 2;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        write_en;
	logic        write_index;
	logic [23:0] write_data;
	int unsigned failures;
	int unsigned pending;
	bit          no_gaps;
	int          bytes_sent;

	fic_byte_if   image_ch ();
	fic_result_if result_ch ();

	firmware_image_checksum dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.image      (image_ch),
		.checksum   (result_ch),
		.write_en   (write_en),
		.write_index(write_index),
		.write_data (write_data)
	);

	fic_checker check_u (
		.clk        (clk),
		.arst_n     (arst_n),
		.image      (image_ch),
		.checksum   (result_ch),
		.write_en   (write_en),
		.write_index(write_index),
		.write_data (write_data),
		.failures   (failures),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle gaps: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [1:0] pick_mode();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return MODE_SUM;
		if (r < 80) return MODE_CRC;
		if (r < 90) return MODE_NONE;
		return MODE_SPARE;
	endfunction

	// Small windows give overruns, the largest ones give heavy padding.
	function automatic logic [23:0] pick_window();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) return 24'($urandom_range(8, 40));
		if (r < 50) return 24'($urandom_range(41, 400));
		if (r < 60) return 24'hFF_FFFF;
		if (r < 65) return 24'hFF_FFFC;
		if (r < 70) return WINDOW_RST;
		if (r < 75) return 24'($urandom_range(0, 7));
		return 24'($urandom);
	endfunction

	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85) return $urandom_range(1, 24);
		if (r < 97) return $urandom_range(25, 120);
		return $urandom_range(121, 400);
	endfunction

	// Present one byte at a falling edge and hold it until a transaction takes it.
	task automatic put_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			image_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		image_ch.valid     <= 1'b1;
		image_ch.data_byte <= b;
		image_ch.last_byte <= last;
		do @(posedge clk); while (!image_ch.ready);
		bytes_sent++;
	endtask

	task automatic send_image(input int len, input bit finish, input int fill);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			case (fill)
				FILL_ZERO: b = 8'h00;
				FILL_ONES: b = 8'hFF;
				default: b = 8'($urandom);
			endcase
			put_byte(b, finish && (i == len - 1));
		end
	endtask

	// Stop sending, wait for every expected checksum, then let the pipeline settle.
	task automatic drain();
		@(negedge clk);
		image_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(input logic idx, input logic [23:0] value);
		@(negedge clk);
		write_en    <= 1'b1;
		write_index <= idx;
		write_data  <= value;
		@(negedge clk);
		write_en <= 1'b0;
	endtask

	// Only the low two bits select the mode; the rest carry noise.
	task automatic set_mode(input logic [1:0] m);
		logic [21:0] junk;
		junk = 22'($urandom);
		cfg_write(CFG_MODE, {junk, m});
	endtask

	// Result side: random stalls of mixed length and long ready stretches.
	initial begin : result_ready
		int low;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 9) < 3) begin
				result_ch.ready <= 1'b1;
				repeat ($urandom_range(10, 80)) @(negedge clk);
			end else begin
				low = pick_gap();
				if (low > 0) begin
					result_ch.ready <= 1'b0;
					repeat (low) @(negedge clk);
				end
				result_ch.ready <= 1'b1;
				repeat ($urandom_range(0, 3)) @(negedge clk);
			end
		end
	end

	initial begin : stimulus
		int  images;
		bit  wrote_mode;
		arst_n             = 1'b0;
		write_en           = 1'b0;
		write_index        = CFG_MODE;
		write_data         = '0;
		image_ch.valid     = 1'b0;
		image_ch.data_byte = '0;
		image_ch.last_byte = 1'b0;
		no_gaps            = 1'b0;
		bytes_sent         = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// CRC from the reset configuration: whole words of extreme bytes and a short image.
		send_image(4, 1'b1, FILL_ZERO);
		send_image(4, 1'b1, FILL_ONES);
		send_image(1, 1'b1, FILL_ONES);

		// Sum in a window of 8 bytes: a fit, then an overrun with a partial last word.
		drain();
		set_mode(MODE_SUM);
		cfg_write(CFG_WINDOW, 24'd8);
		send_image(4, 1'b1, FILL_ONES);
		send_image(5, 1'b1, FILL_ONES);

		// Largest window pads with millions of erased words; a tiny window pads nothing.
		drain();
		cfg_write(CFG_WINDOW, 24'hFF_FFFF);
		send_image(2, 1'b1, FILL_ONES);
		drain();
		cfg_write(CFG_WINDOW, 24'd2);
		send_image(1, 1'b1, FILL_ZERO);

		// A mode write in the middle of an image throws the image away.
		send_image(2, 1'b0, FILL_RANDOM);
		drain();
		set_mode(MODE_NONE);
		send_image(1, 1'b1, FILL_RANDOM);
		drain();
		set_mode(MODE_SPARE);
		send_image(1, 1'b1, FILL_RANDOM);

		// A window write in the middle of an image keeps the partial sum.
		drain();
		set_mode(MODE_SUM);
		send_image(2, 1'b0, FILL_ONES);
		drain();
		cfg_write(CFG_WINDOW, 24'd12);
		send_image(3, 1'b1, FILL_RANDOM);

		// Random phases of images, each under a fresh configuration.
		bytes_sent = 0;
		while (bytes_sent < 2000) begin
			drain();
			wrote_mode = 1'b0;
			if ($urandom_range(0, 4) != 0) begin
				set_mode(pick_mode());
				wrote_mode = 1'b1;
			end
			if (!wrote_mode || $urandom_range(0, 2) != 0) cfg_write(CFG_WINDOW, pick_window());
			no_gaps = ($urandom_range(0, 3) == 0);
			images = $urandom_range(3, 12);
			for (int k = 0; k < images; k++)
				send_image(pick_len(), (k < images - 1) || ($urandom_range(0, 4) != 0),
					FILL_RANDOM);
		end
		no_gaps = 1'b0;
		drain();

		if (failures == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
